// ----- design/assert_macros.svh -----
// Assertion macros shared by the sensor event credit sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SECS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define SECS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- design/secs_pkg.sv -----
// Types and constants of the sensor event credit sequencer
package secs_pkg;

   localparam int unsigned TASK_PRESCALE_DEF = 4;
   localparam int unsigned CNT_W  = 16;
   localparam int unsigned EVT_W  = 8;
   localparam int unsigned ADDR_W = 5;
   localparam int unsigned DATA_W = 32;

   localparam logic [CNT_W-1:0] SETTLE_RST  = 16'd8;
   localparam logic [CNT_W-1:0] SAMPLE_RST  = 16'd600;
   localparam logic [CNT_W-1:0] CREDIT_RST  = 16'd60;
   localparam logic [EVT_W-1:0] MAX_CR_RST  = 8'd4;
   localparam logic [CNT_W-1:0] LED_RST     = 16'd4;
   localparam logic [CNT_W-1:0] REPEATS_RST = 16'd1;
   localparam logic [EVT_W-1:0] CREDIT_INIT = 8'd1;

   typedef enum logic [3:0] {
      PH_SETTLE    = 4'd0,
      PH_WAIT      = 4'd1,
      PH_TASKS     = 4'd2,
      PH_M_TX      = 4'd3,
      PH_M_LED     = 4'd4,
      PH_S_TX      = 4'd5,
      PH_S_LED     = 4'd6,
      PH_SAMPLE    = 4'd7,
      PH_SAMPLE_TX = 4'd8,
      PH_HALT      = 4'd9
   } phase_type;

   typedef enum logic [1:0] {
      LED_OFF  = 2'd0,
      LED_RED  = 2'd1,
      LED_GRN  = 2'd2,
      LED_KEEP = 2'd3
   } led_type;

   typedef enum logic [2:0] {
      REG_SETTLE     = 3'd0,
      REG_SAMPLE     = 3'd1,
      REG_CREDIT     = 3'd2,
      REG_MAX_MOTION = 3'd3,
      REG_MAX_SWITCH = 3'd4,
      REG_MOTION_LED = 3'd5,
      REG_SWITCH_LED = 3'd6,
      REG_REPEATS    = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic [CNT_W-1:0] settle_ticks;
      logic [CNT_W-1:0] sample_period;
      logic [CNT_W-1:0] credit_period;
      logic [EVT_W-1:0] motion_credit_cap;
      logic [EVT_W-1:0] switch_credit_cap;
      logic [CNT_W-1:0] motion_led_ticks;
      logic [CNT_W-1:0] switch_led_ticks;
      logic [CNT_W-1:0] sample_repeats;
   } cfg_type;

   typedef struct packed {
      logic [EVT_W-1:0] motion_new;
      logic [EVT_W-1:0] switch_new;
      logic             battery_low;
      logic             radio_failed;
      logic             button_released;
   } req_type;

   typedef struct packed {
      logic       send_packet;
      logic       take_sample;
      logic       check_radio;
      logic [1:0] led;
      logic       halted;
      logic [3:0] phase;
   } rsp_type;

endpackage

// ----- design/secs_csr.sv -----
// Configuration register file with APB-style access
module secs_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [secs_pkg::ADDR_W-1:0]   paddr,
   input  logic [secs_pkg::DATA_W-1:0]   pwdata,
   output logic [secs_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output secs_pkg::cfg_type             cfg
);

   secs_pkg::cfg_type     cfg_ff, cfg_in;
   secs_pkg::reg_idx_type idx;
   logic                  wr_en;

   assign idx    = secs_pkg::reg_idx_type'(paddr[secs_pkg::ADDR_W-1:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            secs_pkg::REG_SETTLE:     cfg_in.settle_ticks      = pwdata[15:0];
            secs_pkg::REG_SAMPLE:     cfg_in.sample_period     = pwdata[15:0];
            secs_pkg::REG_CREDIT:     cfg_in.credit_period     = pwdata[15:0];
            secs_pkg::REG_MAX_MOTION: cfg_in.motion_credit_cap = pwdata[7:0];
            secs_pkg::REG_MAX_SWITCH: cfg_in.switch_credit_cap = pwdata[7:0];
            secs_pkg::REG_MOTION_LED: cfg_in.motion_led_ticks  = pwdata[15:0];
            secs_pkg::REG_SWITCH_LED: cfg_in.switch_led_ticks  = pwdata[15:0];
            secs_pkg::REG_REPEATS:    cfg_in.sample_repeats    = pwdata[15:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         secs_pkg::REG_SETTLE:     prdata = {16'd0, cfg_ff.settle_ticks};
         secs_pkg::REG_SAMPLE:     prdata = {16'd0, cfg_ff.sample_period};
         secs_pkg::REG_CREDIT:     prdata = {16'd0, cfg_ff.credit_period};
         secs_pkg::REG_MAX_MOTION: prdata = {24'd0, cfg_ff.motion_credit_cap};
         secs_pkg::REG_MAX_SWITCH: prdata = {24'd0, cfg_ff.switch_credit_cap};
         secs_pkg::REG_MOTION_LED: prdata = {16'd0, cfg_ff.motion_led_ticks};
         secs_pkg::REG_SWITCH_LED: prdata = {16'd0, cfg_ff.switch_led_ticks};
         secs_pkg::REG_REPEATS:    prdata = {16'd0, cfg_ff.sample_repeats};
         default:                  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_ticks      <= secs_pkg::SETTLE_RST;
         cfg_ff.sample_period     <= secs_pkg::SAMPLE_RST;
         cfg_ff.credit_period     <= secs_pkg::CREDIT_RST;
         cfg_ff.motion_credit_cap <= secs_pkg::MAX_CR_RST;
         cfg_ff.switch_credit_cap <= secs_pkg::MAX_CR_RST;
         cfg_ff.motion_led_ticks  <= secs_pkg::LED_RST;
         cfg_ff.switch_led_ticks  <= secs_pkg::LED_RST;
         cfg_ff.sample_repeats    <= secs_pkg::REPEATS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- design/secs_core.sv -----
// Sequencer state and the per-tick phase step
module secs_core #(
   parameter int unsigned TASK_PRESCALE = secs_pkg::TASK_PRESCALE_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  secs_pkg::cfg_type   cfg,
   input  secs_pkg::req_type   req,
   output secs_pkg::rsp_type   rsp,
   output secs_pkg::phase_type phase_now
);

   localparam int unsigned STEP_MAX = 3;
   localparam logic [secs_pkg::CNT_W-1:0] PRESCALE = secs_pkg::CNT_W'(TASK_PRESCALE);

   secs_pkg::phase_type              phase_ff, phase_in;
   logic [secs_pkg::CNT_W-1:0]       pcount_ff, pcount_in;
   logic [secs_pkg::CNT_W-1:0]       scount_ff, scount_in;
   logic [secs_pkg::CNT_W-1:0]       ccount_ff, ccount_in;
   logic [secs_pkg::EVT_W-1:0]       mcred_ff, mcred_in;
   logic [secs_pkg::EVT_W-1:0]       scred_ff, scred_in;
   logic [secs_pkg::EVT_W-1:0]       mpend_ff, mpend_in;
   logic [secs_pkg::EVT_W-1:0]       spend_ff, spend_in;

   logic              step_go;
   logic              tx;
   logic              smp;
   logic              chk;
   secs_pkg::led_type led_v;

   always_comb begin
      phase_in  = phase_ff;
      pcount_in = pcount_ff;
      scount_in = scount_ff;
      ccount_in = ccount_ff;
      mcred_in  = mcred_ff;
      scred_in  = scred_ff;
      mpend_in  = mpend_ff;
      spend_in  = spend_ff;
      tx        = 1'b0;
      smp       = 1'b0;
      chk       = 1'b0;
      led_v     = secs_pkg::LED_KEEP;
      step_go   = 1'b0;

      if (phase_ff != secs_pkg::PH_HALT) begin
         if (scount_ff == '0) begin
            scount_in = cfg.sample_period;
            chk       = 1'b1;
            phase_in  = secs_pkg::PH_SAMPLE;
         end else begin
            scount_in = scount_ff - 16'd1;
         end

         if (ccount_ff == '0) begin
            ccount_in = cfg.credit_period;
            if (mcred_ff < cfg.motion_credit_cap) mcred_in = mcred_ff + 8'd1;
            if (scred_ff < cfg.switch_credit_cap) scred_in = scred_ff + 8'd1;
         end else begin
            ccount_in = ccount_ff - 16'd1;
         end

         mpend_in = mpend_ff + req.motion_new;
         spend_in = spend_ff + req.switch_new;

         // at most settle -> wait -> tasks in one tick
         step_go = 1'b1;
         for (int i = 0; i < STEP_MAX; i++) begin
            if (step_go) begin
               step_go = 1'b0;
               case (phase_in)
                  secs_pkg::PH_SETTLE: begin
                     led_v = secs_pkg::LED_OFF;
                     if (pcount_in != '0) begin
                        pcount_in = pcount_in - 16'd1;
                     end else begin
                        pcount_in = PRESCALE;
                        phase_in  = secs_pkg::PH_WAIT;
                        step_go   = 1'b1;
                     end
                  end
                  secs_pkg::PH_WAIT: begin
                     if (pcount_in >= 16'd2) begin
                        pcount_in = pcount_in - 16'd1;
                     end else begin
                        phase_in = secs_pkg::PH_TASKS;
                        step_go  = 1'b1;
                     end
                  end
                  secs_pkg::PH_TASKS: begin
                     if (mpend_in != '0) begin
                        phase_in = secs_pkg::PH_M_TX;
                     end else if (spend_in != '0) begin
                        phase_in = secs_pkg::PH_S_TX;
                     end else begin
                        pcount_in = PRESCALE;
                        phase_in  = secs_pkg::PH_WAIT;
                     end
                  end
                  secs_pkg::PH_M_TX: begin
                     if (mcred_in != '0) begin
                        tx       = 1'b1;
                        mcred_in = mcred_in - 8'd1;
                     end
                     pcount_in = cfg.motion_led_ticks;
                     phase_in  = secs_pkg::PH_M_LED;
                     step_go   = 1'b1;
                  end
                  secs_pkg::PH_M_LED: begin
                     led_v = secs_pkg::LED_RED;
                     if (pcount_in == '0) begin
                        led_v     = secs_pkg::LED_OFF;
                        mpend_in  = '0;
                        pcount_in = cfg.settle_ticks;
                        phase_in  = secs_pkg::PH_SETTLE;
                     end else begin
                        pcount_in = pcount_in - 16'd1;
                     end
                  end
                  secs_pkg::PH_S_TX: begin
                     if (scred_in != '0) begin
                        tx       = 1'b1;
                        scred_in = scred_in - 8'd1;
                     end
                     pcount_in = cfg.switch_led_ticks;
                     phase_in  = secs_pkg::PH_S_LED;
                     step_go   = 1'b1;
                  end
                  secs_pkg::PH_S_LED: begin
                     led_v = secs_pkg::LED_GRN;
                     if (pcount_in == '0) begin
                        led_v     = secs_pkg::LED_OFF;
                        spend_in  = '0;
                        pcount_in = cfg.settle_ticks;
                        phase_in  = secs_pkg::PH_SETTLE;
                     end else begin
                        pcount_in = pcount_in - 16'd1;
                     end
                  end
                  secs_pkg::PH_SAMPLE: begin
                     led_v     = secs_pkg::LED_OFF;
                     smp       = 1'b1;
                     pcount_in = cfg.sample_repeats;
                     phase_in  = secs_pkg::PH_SAMPLE_TX;
                     step_go   = 1'b1;
                  end
                  secs_pkg::PH_SAMPLE_TX: begin
                     if (pcount_in == '0) begin
                        pcount_in = cfg.settle_ticks;
                        phase_in  = secs_pkg::PH_SETTLE;
                     end else begin
                        pcount_in = pcount_in - 16'd1;
                        tx        = 1'b1;
                     end
                  end
                  default: begin
                     phase_in = secs_pkg::PH_SETTLE;
                  end
               endcase
            end
         end

         if (req.button_released) begin
            mcred_in  = cfg.motion_credit_cap;
            scred_in  = cfg.switch_credit_cap;
            pcount_in = cfg.settle_ticks;
            phase_in  = secs_pkg::PH_SETTLE;
         end

         if (req.battery_low || req.radio_failed) phase_in = secs_pkg::PH_HALT;
      end

      rsp.send_packet = tx;
      rsp.take_sample = smp;
      rsp.check_radio = chk;
      rsp.led         = led_v;
      rsp.halted      = (phase_in == secs_pkg::PH_HALT);
      rsp.phase       = phase_in;
   end

   assign phase_now = phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= secs_pkg::PH_SETTLE;
         pcount_ff <= secs_pkg::SETTLE_RST;
         scount_ff <= secs_pkg::SAMPLE_RST;
         ccount_ff <= secs_pkg::CREDIT_RST;
         mcred_ff  <= secs_pkg::CREDIT_INIT;
         scred_ff  <= secs_pkg::CREDIT_INIT;
         mpend_ff  <= '0;
         spend_ff  <= '0;
      end else if (adv) begin
         phase_ff  <= phase_in;
         pcount_ff <= pcount_in;
         scount_ff <= scount_in;
         ccount_ff <= ccount_in;
         mcred_ff  <= mcred_in;
         scred_ff  <= scred_in;
         mpend_ff  <= mpend_in;
         spend_ff  <= spend_in;
      end
   end

endmodule

// ----- design/sensor_event_credit_sequencer.sv -----
// A word taken on req passes the input register, then the result register on rsp.
// Throughput: one word per cycle unless rsp_stall holds the output; the tick step
// is one pass between the two registers, state updated in that pass.
// Reset: synchronous, active high; clears both stages, loads the
// registers with their defaults and the state with its start values.
`include "assert_macros.svh"

module sensor_event_credit_sequencer #(
   parameter int unsigned TASK_PRESCALE = secs_pkg::TASK_PRESCALE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  secs_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output secs_pkg::rsp_type             rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [secs_pkg::ADDR_W-1:0]   paddr,
   input  logic [secs_pkg::DATA_W-1:0]   pwdata,
   output logic [secs_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);

   logic                s1_valid_ff, s1_valid_in;
   secs_pkg::req_type   s1_data_ff, s1_data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   secs_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic                out_free;
   logic                adv;
   secs_pkg::cfg_type   cfg;
   secs_pkg::rsp_type   step_rsp;
   secs_pkg::phase_type phase_now;
   logic                halted_now;

   secs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   secs_core #(
      .TASK_PRESCALE (TASK_PRESCALE)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg),
      .req       (s1_data_ff),
      .rsp       (step_rsp),
      .phase_now (phase_now)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign adv        = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign halted_now = (phase_now == secs_pkg::PH_HALT);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (req_valid && !req_stall) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data;
      end else if (adv) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (adv) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_rsp;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   // no word appears without one in the input stage
   `SECS_ASSERT_NXT(a_no_phantom, clock, reset, rsp_valid && !rsp_stall && !s1_valid_ff, !rsp_valid)
   // a halt is final until reset
   `SECS_ASSERT_NXT(a_halt_sticks, clock, reset, halted_now, halted_now)
   // a sample only comes with the timer that also asks for a radio check
   `SECS_ASSERT_IMP(a_sample_check, clock, reset, rsp_valid && rsp_data.take_sample, rsp_data.check_radio)

endmodule
